FILE: sv/sbdk_pkg.sv
`default_nettype none

package sbdk_pkg;

    // Bus operation codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_MEM_READ  = 3'd1;
    localparam logic [2:0] OP_MEM_WRITE = 3'd2;
    localparam logic [2:0] OP_IO_IN     = 3'd3;
    localparam logic [2:0] OP_IO_OUT    = 3'd4;
    localparam logic [2:0] OP_KEY_PRESS = 3'd5;

    // I/O pages
    localparam logic [7:0] PAGE_BOARD = 8'h00;
    localparam logic [7:0] PAGE_GFX   = 8'h01;
    localparam logic [7:0] PAGE_SND   = 8'h02;

    // Motherboard ports
    localparam logic [7:0] PORT_KEY_STATUS = 8'h20;
    localparam logic [7:0] PORT_KEY_DATA   = 8'h21;
    localparam logic [7:0] PORT_DMA_CNT_HI = 8'h40;
    localparam logic [7:0] PORT_DMA_CNT_LO = 8'h41;
    localparam logic [7:0] PORT_DMA_SRC_HI = 8'h42;
    localparam logic [7:0] PORT_DMA_SRC_LO = 8'h43;
    localparam logic [7:0] PORT_DMA_START  = 8'h44;

    // Forward targets
    localparam logic [1:0] FWD_NONE = 2'd0;
    localparam logic [1:0] FWD_GFX  = 2'd1;
    localparam logic [1:0] FWD_SND  = 2'd2;

    localparam logic [15:0] DMA_GFX_PORT = 16'h0012;
    localparam logic [7:0]  KEY_EMPTY    = 8'hFF;

    // Sound divider, Q8.10 period and Q9.10 phase
    localparam logic [17:0] APU_PERIOD_RESET = 18'd232199;
    localparam logic [19:0] PHASE_ONE        = 20'd1024;
    localparam logic [18:0] PHASE_MAX        = 19'h7FFFF;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_ACCESS,
        CTL_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic access;
        logic finish;
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: sv/sbdk_ctrl.sv
`default_nettype none

module sbdk_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output logic                 done,
    output sbdk_pkg::dp_cmd_t    cmd
);

    sbdk_pkg::ctl_state_t state_reg;
    sbdk_pkg::ctl_state_t state_next;
    logic                 done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbdk_pkg::CTL_IDLE:
            begin
                if (start)
                begin
                    state_next = sbdk_pkg::CTL_ACCESS;
                end
            end
            sbdk_pkg::CTL_ACCESS: state_next = sbdk_pkg::CTL_FINISH;
            sbdk_pkg::CTL_FINISH: state_next = sbdk_pkg::CTL_IDLE;
            default:              state_next = sbdk_pkg::CTL_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != sbdk_pkg::CTL_IDLE);
        cmd.capture = (state_reg == sbdk_pkg::CTL_IDLE) && start;
        cmd.access  = (state_reg == sbdk_pkg::CTL_ACCESS);
        cmd.finish  = (state_reg == sbdk_pkg::CTL_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbdk_pkg::CTL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: sv/sbdk_datapath.sv
`default_nettype none

module sbdk_datapath #(
    parameter int RAM_BYTES = 32768,
    parameter int KEY_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbdk_pkg::dp_cmd_t cmd,
    input  wire logic [2:0]        opcode,
    input  wire logic [15:0]       address,
    input  wire logic [7:0]        data,
    input  wire logic              cfg_write,
    input  wire logic [17:0]       cfg_data,
    output logic [7:0]             read_data,
    output logic                   cpu_step,
    output logic                   apu_step,
    output logic [1:0]             fwd_target,
    output logic                   fwd_write,
    output logic [15:0]            fwd_address,
    output logic [7:0]             fwd_data
);

    localparam int RW = $clog2(RAM_BYTES);
    localparam int KW = $clog2(KEY_DEPTH);

    // Request capture
    logic [2:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // Machine state
    logic [17:0]   apu_period_reg;
    logic [KW-1:0] key_wr_reg, key_wr_next;
    logic [KW-1:0] key_rd_reg, key_rd_next;
    logic          active_reg, active_next;
    logic [15:0]   count_reg, count_next;
    logic [15:0]   source_reg, source_next;
    logic [18:0]   phase_reg, phase_next;

    // Memories and their registered read data
    logic [7:0] main_mem [RAM_BYTES];
    logic [7:0] key_mem  [KEY_DEPTH];
    logic [7:0] ram_q_reg;
    logic [7:0] key_q_reg;
    logic       in_ram_reg;

    logic [15:0] ram_addr;
    logic        in_ram;

    // Result
    logic [7:0]  rd_next;
    logic        cpu_next, apu_next, fw_next;
    logic [1:0]  tgt_next;
    logic [15:0] fa_next;
    logic [7:0]  fd_next;

    logic [7:0]  page;
    logic [7:0]  port;
    logic        key_empty;
    logic        phase_over;
    logic [18:0] phase_sub;
    logic [19:0] phase_sum;
    logic [7:0]  ram_byte;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            data_reg <= data;
        end
    end

    // Tick reads the DMA source, everything else the bus address
    assign ram_addr = (op_reg == sbdk_pkg::OP_TICK) ? source_reg : addr_reg;
    assign in_ram   = ({1'b0, ram_addr} < 17'(RAM_BYTES));

    always_ff @(posedge clk)
    begin
        if (cmd.access)
        begin
            if ((op_reg == sbdk_pkg::OP_MEM_WRITE) && in_ram)
            begin
                main_mem[ram_addr[RW-1:0]] <= data_reg;
            end
            ram_q_reg  <= main_mem[ram_addr[RW-1:0]];
            in_ram_reg <= in_ram;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.access)
        begin
            if (op_reg == sbdk_pkg::OP_KEY_PRESS)
            begin
                key_mem[key_wr_reg] <= data_reg;
            end
            key_q_reg <= key_mem[key_rd_reg];
        end
    end

    assign page      = addr_reg[15:8];
    assign port      = addr_reg[7:0];
    assign key_empty = (key_wr_reg == key_rd_reg);
    assign ram_byte  = in_ram_reg ? ram_q_reg : 8'h00;

    // Fractional sound divider: subtract period when passed, add one, saturate
    assign phase_over = (phase_reg > {1'b0, apu_period_reg});
    assign phase_sub  = phase_over ? (phase_reg - {1'b0, apu_period_reg}) : phase_reg;
    assign phase_sum  = {1'b0, phase_sub} + sbdk_pkg::PHASE_ONE;

    always_comb
    begin
        rd_next     = 8'h00;
        cpu_next    = 1'b0;
        apu_next    = 1'b0;
        tgt_next    = sbdk_pkg::FWD_NONE;
        fw_next     = 1'b0;
        fa_next     = 16'h0000;
        fd_next     = 8'h00;
        key_wr_next = key_wr_reg;
        key_rd_next = key_rd_reg;
        active_next = active_reg;
        count_next  = count_reg;
        source_next = source_reg;
        phase_next  = phase_reg;

        unique case (op_reg)
            sbdk_pkg::OP_TICK:
            begin
                if (active_reg)
                begin
                    if (count_reg == 16'h0000)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        tgt_next    = sbdk_pkg::FWD_GFX;
                        fw_next     = 1'b1;
                        fa_next     = sbdk_pkg::DMA_GFX_PORT;
                        fd_next     = ram_byte;
                        source_next = source_reg + 16'd1;
                        count_next  = count_reg - 16'd1;
                    end
                end
                else
                begin
                    cpu_next = 1'b1;
                end
                apu_next   = phase_over;
                phase_next = (phase_sum > {1'b0, sbdk_pkg::PHASE_MAX}) ?
                             sbdk_pkg::PHASE_MAX : phase_sum[18:0];
            end
            sbdk_pkg::OP_MEM_READ:
            begin
                rd_next = ram_byte;
            end
            sbdk_pkg::OP_IO_IN:
            begin
                if (page == sbdk_pkg::PAGE_BOARD)
                begin
                    if (port == sbdk_pkg::PORT_KEY_STATUS)
                    begin
                        rd_next = {7'd0, !key_empty};
                    end
                    else if (port == sbdk_pkg::PORT_KEY_DATA)
                    begin
                        if (key_empty)
                        begin
                            rd_next = sbdk_pkg::KEY_EMPTY;
                        end
                        else
                        begin
                            rd_next     = key_q_reg;
                            key_rd_next = (key_rd_reg == KW'(KEY_DEPTH - 1)) ?
                                          '0 : key_rd_reg + 1'b1;
                        end
                    end
                end
                else if ((page == sbdk_pkg::PAGE_GFX) || (page == sbdk_pkg::PAGE_SND))
                begin
                    tgt_next = page[1:0];
                    fa_next  = addr_reg;
                end
            end
            sbdk_pkg::OP_IO_OUT:
            begin
                if (page == sbdk_pkg::PAGE_BOARD)
                begin
                    unique case (port)
                        sbdk_pkg::PORT_DMA_CNT_HI: count_next  = {data_reg, count_reg[7:0]};
                        sbdk_pkg::PORT_DMA_CNT_LO: count_next  = {count_reg[15:8], data_reg};
                        sbdk_pkg::PORT_DMA_SRC_HI: source_next = {data_reg, source_reg[7:0]};
                        sbdk_pkg::PORT_DMA_SRC_LO: source_next = {source_reg[15:8], data_reg};
                        sbdk_pkg::PORT_DMA_START:  active_next = 1'b1;
                        default:                   active_next = active_reg;
                    endcase
                end
                else if ((page == sbdk_pkg::PAGE_GFX) || (page == sbdk_pkg::PAGE_SND))
                begin
                    tgt_next = page[1:0];
                    fw_next  = 1'b1;
                    fa_next  = addr_reg;
                    fd_next  = data_reg;
                end
            end
            sbdk_pkg::OP_KEY_PRESS:
            begin
                key_wr_next = (key_wr_reg == KW'(KEY_DEPTH - 1)) ? '0 : key_wr_reg + 1'b1;
            end
            default:
            begin
                rd_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apu_period_reg <= sbdk_pkg::APU_PERIOD_RESET;
            key_wr_reg     <= '0;
            key_rd_reg     <= '0;
            active_reg     <= 1'b0;
            count_reg      <= 16'h0000;
            source_reg     <= 16'h0000;
            phase_reg      <= 19'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                apu_period_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                key_wr_reg <= key_wr_next;
                key_rd_reg <= key_rd_next;
                active_reg <= active_next;
                count_reg  <= count_next;
                source_reg <= source_next;
                phase_reg  <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_data   <= rd_next;
            cpu_step    <= cpu_next;
            apu_step    <= apu_next;
            fwd_target  <= tgt_next;
            fwd_write   <= fw_next;
            fwd_address <= fa_next;
            fwd_data    <= fd_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/system_bus_dma_keyboard_controller.sv
// A request is accepted when start is seen while idle and is captured; busy then holds
// off new requests while it makes one RAM/key memory access with registered read data
// and then settles the result and state, which are registered together with done.
// done marks results for one cycle and cannot be stalled; a new request may enter then.
// Reset (rst_n, async, active low) clears control, DMA, keyboard indexes and sound phase
// and loads the default sound period; RAM and the key ring are not cleared.
`default_nettype none

module system_bus_dma_keyboard_controller #(
    parameter int RAM_BYTES = 32768,
    parameter int KEY_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [17:0] cfg_data,
    output logic             done,
    output logic [7:0]       read_data,
    output logic             cpu_step,
    output logic             apu_step,
    output logic [1:0]       fwd_target,
    output logic             fwd_write,
    output logic [15:0]      fwd_address,
    output logic [7:0]       fwd_data
);

    sbdk_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sbdk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sbdk_datapath #(
        .RAM_BYTES (RAM_BYTES),
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .address     (address),
        .data        (data),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .read_data   (read_data),
        .cpu_step    (cpu_step),
        .apu_step    (apu_step),
        .fwd_target  (fwd_target),
        .fwd_write   (fwd_write),
        .fwd_address (fwd_address),
        .fwd_data    (fwd_data)
    );

endmodule

`default_nettype wire

FILE: sv/sbdk_checker.sv
`default_nettype none

module sbdk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        cpu_step,
    input wire logic [1:0]  fwd_target,
    input wire logic        fwd_write,
    input wire logic [15:0] fwd_address
);

    // A result only follows a request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    // An accepted request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // The CPU never steps in a result with a forward target, such as DMA to the graphics port
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(cpu_step && (fwd_target != sbdk_pkg::FWD_NONE)))
        else $error("cpu step during a forwarded access");

    // No forward target means an empty forward payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fwd_target == sbdk_pkg::FWD_NONE)) |->
            (!fwd_write && (fwd_address == 16'h0000)))
        else $error("forward fields set without a target");

endmodule

bind system_bus_dma_keyboard_controller sbdk_checker u_sbdk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .cpu_step    (cpu_step),
    .fwd_target  (fwd_target),
    .fwd_write   (fwd_write),
    .fwd_address (fwd_address)
);

`default_nettype wire
